### hw/rtl/tbvs_pkg.sv
// constants, widths and types of the two-bone vertex skinning pipeline
// no dependencies; imported by two_bone_vertex_skinning, skin_result_checker and the testbench top
package tbvs_pkg;

  localparam int NUM_BONES   = 2;
  localparam int FRAC_BITS   = 16;
  localparam int MAT_ROWS    = 3;
  localparam int MAT_COLS    = 4;
  localparam int MAT_WORDS   = MAT_ROWS * MAT_COLS;
  localparam int BLEND_BONES = 2;
  localparam int COORDS      = 3;

  localparam int WORD_W      = 32;
  localparam int ENTRY_W     = 4;
  localparam int WEIGHT_W    = 16;
  localparam int WEIGHT_FRAC = 15;

  localparam int PROD_W = 2 * WORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int ROW_W  = SUM_W - FRAC_BITS;
  localparam int DIFF_W = WORD_W + 1;
  localparam int LERP_W = DIFF_W + WEIGHT_W + 1;
  localparam int Q_W    = LERP_W - WEIGHT_FRAC;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_VERTEX = 1'b1;

  typedef logic signed [WORD_W-1:0]   word_t;
  typedef logic        [WEIGHT_W-1:0] weight_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [ROW_W-1:0]    row_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [LERP_W-1:0]   lerp_t;
  typedef logic signed [Q_W-1:0]      q_t;

  localparam weight_t W_ONE      = weight_t'(1 << WEIGHT_FRAC);
  localparam word_t   WORD_MAX   = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t   WORD_MIN   = {1'b1, {(WORD_W-1){1'b0}}};
  localparam sum_t    ROW_ROUND  = sum_t'(1) <<< (FRAC_BITS - 1);
  localparam lerp_t   LERP_ROUND = lerp_t'(1) <<< (WEIGHT_FRAC - 1);

endpackage

### hw/rtl/two_bone_vertex_skinning.sv
// two-bone linear blend skinning pipeline, top level
// depends on tbvs_pkg for widths, types and mode codes
//
// Takes one item per cycle unless a result waits under out_stall. A load
// item (mode 0) writes one word of a bone's 3x4 affine matrix and gives
// no result. A vertex item (mode 1) gives one result, in order, with any
// mix of loads and vertices back to back. A vertex always sees every load
// transferred before it. The stages are: input register, the 18
// matrix-by-coordinate 32x32 products, the row sums, floor shift and
// clamp, bone difference, weight multiply, and rounding into the output
// register. The whole pipeline holds while a result waits under
// out_stall, so in_stall follows the output side. Matrix words read
// before they were written give undefined results.
module two_bone_vertex_skinning import tbvs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      mode,
  input  logic                      bone_index,
  input  logic [ENTRY_W-1:0]        entry_index,
  input  logic signed [WORD_W-1:0]  entry_value,
  input  logic signed [WORD_W-1:0]  pos_x,
  input  logic signed [WORD_W-1:0]  pos_y,
  input  logic signed [WORD_W-1:0]  pos_z,
  input  logic [WEIGHT_W-1:0]       weight_zero,
  input  logic [WEIGHT_W-1:0]       weight_one,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [WORD_W-1:0]  out_x,
  output logic signed [WORD_W-1:0]  out_y,
  output logic signed [WORD_W-1:0]  out_z,
  output logic                      blended,
  output logic                      saturated
);

  logic adv;

  // stage 0: input register
  logic               v0;
  logic               mode0;
  logic               bone0;
  logic [ENTRY_W-1:0] entry0;
  word_t              value0;
  word_t              pos0 [COORDS];
  logic               pt0;
  weight_t            w1c0;

  word_t mat [NUM_BONES][MAT_WORDS];

  // stage 1: products
  logic    v1;
  logic    pt1;
  weight_t w1c1;
  word_t   pos1 [COORDS];
  prod_t   prod1 [BLEND_BONES][MAT_ROWS][COORDS];
  sum_t    k1 [BLEND_BONES][MAT_ROWS];

  // stage 2: row sums
  logic    v2;
  logic    pt2;
  weight_t w1c2;
  word_t   pos2 [COORDS];
  sum_t    sum2 [BLEND_BONES][MAT_ROWS];

  // stage 3: clamped rows
  logic    v3;
  logic    pt3;
  weight_t w1c3;
  word_t   pos3 [COORDS];
  word_t   p3 [BLEND_BONES][MAT_ROWS];
  logic    clamp3;
  word_t   p3_next [BLEND_BONES][MAT_ROWS];
  logic    clamp3_next;

  // stage 4: bone difference
  logic    v4;
  logic    pt4;
  weight_t w1c4;
  word_t   pos4 [COORDS];
  word_t   base4 [MAT_ROWS];
  diff_t   d4 [MAT_ROWS];
  logic    clamp4;

  // stage 5: weight product
  logic    v5;
  logic    pt5;
  word_t   pos5 [COORDS];
  word_t   base5 [MAT_ROWS];
  lerp_t   m5 [MAT_ROWS];
  logic    clamp5;

  word_t   res_next [MAT_ROWS];

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v0        <= in_valid;
      v1        <= v0 && (mode0 == MODE_VERTEX);
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode0   <= mode;
      bone0   <= bone_index;
      entry0  <= entry_index;
      value0  <= entry_value;
      pos0[0] <= pos_x;
      pos0[1] <= pos_y;
      pos0[2] <= pos_z;
      pt0     <= (weight_zero >= W_ONE) && (weight_one >= W_ONE);
      w1c0    <= (weight_one > W_ONE) ? W_ONE : weight_one;
    end
  end

  // matrix words, written by a load as it leaves stage 0
  always_ff @(posedge clk) begin
    if (adv && v0 && (mode0 == MODE_LOAD)) begin
      for (int b = 0; b < NUM_BONES; b++) begin
        for (int e = 0; e < MAT_WORDS; e++) begin
          if ((int'(bone0) == b) && (int'(entry0) == e)) begin
            mat[b][e] <= value0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt1  <= pt0;
      w1c1 <= w1c0;
      pos1 <= pos0;
      for (int b = 0; b < BLEND_BONES; b++) begin
        for (int r = 0; r < MAT_ROWS; r++) begin
          for (int c = 0; c < COORDS; c++) begin
            prod1[b][r][c] <= prod_t'(mat[b][r*MAT_COLS+c]) * prod_t'(pos0[c]);
          end
          k1[b][r] <= (sum_t'(mat[b][r*MAT_COLS+COORDS]) <<< FRAC_BITS) + ROW_ROUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt2  <= pt1;
      w1c2 <= w1c1;
      pos2 <= pos1;
      for (int b = 0; b < BLEND_BONES; b++) begin
        for (int r = 0; r < MAT_ROWS; r++) begin
          sum2[b][r] <= sum_t'(prod1[b][r][0]) + sum_t'(prod1[b][r][1])
                      + sum_t'(prod1[b][r][2]) + k1[b][r];
        end
      end
    end
  end

  always_comb begin
    row_t row;
    clamp3_next = 1'b0;
    for (int b = 0; b < BLEND_BONES; b++) begin
      for (int r = 0; r < MAT_ROWS; r++) begin
        row = sum2[b][r][SUM_W-1:FRAC_BITS];
        if ((&row[ROW_W-1:WORD_W-1]) || !(|row[ROW_W-1:WORD_W-1])) begin
          p3_next[b][r] = row[WORD_W-1:0];
        end else begin
          p3_next[b][r] = row[ROW_W-1] ? WORD_MIN : WORD_MAX;
          clamp3_next   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt3    <= pt2;
      w1c3   <= w1c2;
      pos3   <= pos2;
      p3     <= p3_next;
      clamp3 <= clamp3_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt4    <= pt3;
      w1c4   <= w1c3;
      pos4   <= pos3;
      clamp4 <= clamp3;
      for (int r = 0; r < MAT_ROWS; r++) begin
        base4[r] <= p3[0][r];
        d4[r]    <= diff_t'(p3[1][r]) - diff_t'(p3[0][r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt5    <= pt4;
      pos5   <= pos4;
      clamp5 <= clamp4;
      base5  <= base4;
      for (int r = 0; r < MAT_ROWS; r++) begin
        m5[r] <= lerp_t'(d4[r]) * lerp_t'($signed({1'b0, w1c4}));
      end
    end
  end

  // lerp result lies between the two bone positions, so it needs no clamp
  always_comb begin
    lerp_t rounded;
    q_t    sum;
    for (int r = 0; r < MAT_ROWS; r++) begin
      rounded     = m5[r] + LERP_ROUND;
      sum         = q_t'(base5[r]) + q_t'(rounded[LERP_W-1:WEIGHT_FRAC]);
      res_next[r] = pt5 ? pos5[r] : sum[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x     <= res_next[0];
      out_y     <= res_next[1];
      out_z     <= res_next[2];
      blended   <= !pt5;
      saturated <= !pt5 && clamp5;
    end
  end

  a_frozen_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output is held");

  a_pass_not_clamped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !blended) |-> !saturated)
    else $error("pass-through result flagged as clamped");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  a_hold_in_flight: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(v5)))
    else $error("pipeline moved under output stall");

endmodule

### tb/sv/skin_result_checker.sv
`timescale 1ns / 100ps
// transfer monitor, skinning predictor and result scoreboard for two_bone_vertex_skinning
// depends on tbvs_pkg; instantiated beside the block by tb_two_bone_vertex_skinning
module skin_result_checker import tbvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               mode,
  input  logic               bone_index,
  input  logic [ENTRY_W-1:0] entry_index,
  input  word_t              entry_value,
  input  word_t              pos_x,
  input  word_t              pos_y,
  input  word_t              pos_z,
  input  weight_t            weight_zero,
  input  weight_t            weight_one,
  input  logic               out_valid,
  input  logic               out_stall,
  input  word_t              out_x,
  input  word_t              out_y,
  input  word_t              out_z,
  input  logic               blended,
  input  logic               saturated,
  output int                 failures,
  output int                 pending
);

  localparam int REPORT_LIMIT = 10;

  typedef logic signed [79:0] wide_t;

  typedef struct {
    word_t coord [COORDS];
    logic  blended;
    logic  saturated;
  } skin_result_t;

  word_t        matrix_words [NUM_BONES][MAT_WORDS];
  skin_result_t expected_skins [$];

  function automatic logic fits_word(input wide_t v);
    return (v <= wide_t'(WORD_MAX)) && (v >= wide_t'(WORD_MIN));
  endfunction

  function automatic word_t clamp_word(input wide_t v);
    if (v > wide_t'(WORD_MAX)) return WORD_MAX;
    if (v < wide_t'(WORD_MIN)) return WORD_MIN;
    return v[WORD_W-1:0];
  endfunction

  // exact row sum, rounded half up by a floor shift
  function automatic wide_t bone_row(input int bone, input int row, input word_t x, y, z);
    wide_t acc;
    acc = wide_t'(1) <<< (FRAC_BITS - 1);
    acc = acc + wide_t'(matrix_words[bone][row*MAT_COLS + 0]) * wide_t'(x);
    acc = acc + wide_t'(matrix_words[bone][row*MAT_COLS + 1]) * wide_t'(y);
    acc = acc + wide_t'(matrix_words[bone][row*MAT_COLS + 2]) * wide_t'(z);
    acc = acc + (wide_t'(matrix_words[bone][row*MAT_COLS + 3]) <<< FRAC_BITS);
    return acc >>> FRAC_BITS;
  endfunction

  function automatic skin_result_t skin_vertex(input word_t x, y, z, input weight_t w0, w1);
    skin_result_t r;
    wide_t        p0, p1, mix, lerp_w;
    logic         clamped;
    int           i;
    r.coord[0] = x;
    r.coord[1] = y;
    r.coord[2] = z;
    r.blended = 1'b0;
    r.saturated = 1'b0;
    if (!(w0 >= W_ONE && w1 >= W_ONE)) begin
      clamped = 1'b0;
      lerp_w = (w1 > W_ONE) ? wide_t'(W_ONE) : wide_t'(w1);
      for (i = 0; i < COORDS; i++) begin
        p0 = bone_row(0, i, x, y, z);
        p1 = bone_row(1, i, x, y, z);
        clamped = clamped | !fits_word(p0) | !fits_word(p1);
        p0 = wide_t'(clamp_word(p0));
        p1 = wide_t'(clamp_word(p1));
        mix = lerp_w * (p1 - p0) + (wide_t'(1) <<< (WEIGHT_FRAC - 1));
        mix = p0 + (mix >>> WEIGHT_FRAC);
        clamped = clamped | !fits_word(mix);
        r.coord[i] = clamp_word(mix);
      end
      r.blended = 1'b1;
      r.saturated = clamped;
    end
    return r;
  endfunction

  task automatic flag_result(input string why, input string want_text);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display("%s: expected %s, got x=%0d y=%0d z=%0d blended=%0b saturated=%0b",
               why, want_text, out_x, out_y, out_z, blended, saturated);
  endtask

  always @(posedge clk) begin : monitor
    skin_result_t want;
    if (rst) begin
      expected_skins.delete();
      failures = 0;
      pending = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_skins.size() == 0) begin
          flag_result("unexpected result transfer", "nothing");
        end else begin
          want = expected_skins.pop_front();
          if (want.coord[0] !== out_x || want.coord[1] !== out_y ||
              want.coord[2] !== out_z || want.blended !== blended ||
              want.saturated !== saturated)
            flag_result("result mismatch",
                        $sformatf("x=%0d y=%0d z=%0d blended=%0b saturated=%0b",
                                  want.coord[0], want.coord[1], want.coord[2],
                                  want.blended, want.saturated));
        end
      end
      if (in_valid && !in_stall) begin
        if (mode == MODE_LOAD) begin
          if (entry_index < MAT_WORDS && bone_index < NUM_BONES)
            matrix_words[bone_index][entry_index] = entry_value;
        end else begin
          expected_skins.push_back(skin_vertex(pos_x, pos_y, pos_z, weight_zero, weight_one));
        end
      end
      pending = expected_skins.size();
    end
  end

endmodule

### tb/sv/tb_two_bone_vertex_skinning.sv
`timescale 1ns / 100ps
// top of the two_bone_vertex_skinning testbench: clock, reset, stimulus, verdict
// depends on tbvs_pkg, two_bone_vertex_skinning and skin_result_checker
module tb_two_bone_vertex_skinning import tbvs_pkg::*;;

  localparam int    RANDOM_ITEMS   = 1500;
  localparam int    LONG_HOLD      = 200;
  localparam int    HOLD_BURST     = 40;
  localparam int    HOLD_AT        = 300;
  localparam int    DRAIN_AT       = 800;
  localparam int    DRAIN_CYCLES   = 20;
  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    ENTRY_TOP      = (1 << ENTRY_W) - 1;
  localparam int    WEIGHT_TOP     = (1 << WEIGHT_W) - 1;
  localparam word_t ONE_Q          = word_t'(1 << FRAC_BITS);

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_kind_e;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               mode;
  logic               bone_index;
  logic [ENTRY_W-1:0] entry_index;
  word_t              entry_value;
  word_t              pos_x;
  word_t              pos_y;
  word_t              pos_z;
  weight_t            weight_zero;
  weight_t            weight_one;
  logic               out_valid;
  logic               out_stall;
  word_t              out_x;
  word_t              out_y;
  word_t              out_z;
  logic               blended;
  logic               saturated;
  int                 failures;
  int                 pending;

  logic  hold_req;
  logic  hold_done;
  int    idle_cycles;
  int    loads_sent;
  int    unused_loads;
  int    vertices_sent;
  int    passes_sent;
  word_t start_matrix [NUM_BONES][MAT_WORDS];

  two_bone_vertex_skinning dut (.*);

  skin_result_checker skin_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic word_t any_word();
    return word_t'($urandom());
  endfunction

  function automatic word_t rand_coord();
    case ($urandom_range(0, 9))
      0: return any_word();
      1: return ($urandom_range(0, 1) == 0) ? WORD_MAX : WORD_MIN;
      default: return word_t'($urandom_range(0, 1 << 25)) - word_t'(1 << 24);
    endcase
  endfunction

  function automatic word_t rand_matrix_word();
    case ($urandom_range(0, 7))
      0: return any_word();
      1, 2, 3, 4, 5: return word_t'($urandom_range(0, 1 << 18)) - word_t'(1 << 17);
      default: return word_t'($urandom_range(0, 1 << 29)) - word_t'(1 << 28);
    endcase
  endfunction

  function automatic weight_t rand_weight();
    case ($urandom_range(0, 5))
      0: return weight_t'($urandom_range(0, WEIGHT_TOP));
      1: return W_ONE;
      2: return '0;
      default: return weight_t'($urandom_range(0, W_ONE));
    endcase
  endfunction

  task automatic drive(input logic m, b, input logic [ENTRY_W-1:0] e, input word_t v,
                       input word_t x, y, z, input weight_t w0, w1);
    @(negedge clk);
    in_valid = 1'b1;
    mode = m;
    bone_index = b;
    entry_index = e;
    entry_value = v;
    pos_x = x;
    pos_y = y;
    pos_z = z;
    weight_zero = w0;
    weight_one = w1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  task automatic load_word(input logic b, input logic [ENTRY_W-1:0] e, input word_t v);
    loads_sent++;
    if (e >= MAT_WORDS) unused_loads++;
    drive(MODE_LOAD, b, e, v, any_word(), any_word(), any_word(),
          weight_t'($urandom_range(0, WEIGHT_TOP)), weight_t'($urandom_range(0, WEIGHT_TOP)));
  endtask

  task automatic skin(input word_t x, y, z, input weight_t w0, w1);
    vertices_sent++;
    if (w0 >= W_ONE && w1 >= W_ONE) passes_sent++;
    drive(MODE_VERTEX, 1'($urandom_range(0, 1)), ENTRY_W'($urandom_range(0, ENTRY_TOP)),
          any_word(), x, y, z, w0, w1);
  endtask

  task automatic random_vertex();
    weight_t w0, w1;
    if ($urandom_range(0, 9) == 0) begin
      w0 = weight_t'($urandom_range(W_ONE, WEIGHT_TOP));
      w1 = weight_t'($urandom_range(W_ONE, WEIGHT_TOP));
    end else begin
      w0 = rand_weight();
      w1 = rand_weight();
    end
    skin(rand_coord(), rand_coord(), rand_coord(), w0, w1);
  endtask

  task automatic random_load();
    logic [ENTRY_W-1:0] e;
    if ($urandom_range(0, 9) == 0)
      e = ENTRY_W'($urandom_range(MAT_WORDS, ENTRY_TOP));
    else
      e = ENTRY_W'($urandom_range(0, MAT_WORDS - 1));
    load_word(1'($urandom_range(0, 1)), e, rand_matrix_word());
  endtask

  // receiver stall patterns, with one long hold-off on request
  initial begin : receiver
    stall_kind_e kind;
    int          stretch;
    out_stall = 1'b0;
    hold_done = 1'b0;
    wait (rst === 1'b0);
    forever begin
      kind = stall_kind_e'($urandom_range(0, 3));
      stretch = $urandom_range(16, 160);
      repeat (stretch) begin
        @(negedge clk);
        if (hold_req && !hold_done) begin
          out_stall = 1'b1;
          repeat (LONG_HOLD) @(negedge clk);
          hold_done = 1'b1;
        end
        case (kind)
          STALL_NONE:  out_stall = 1'b0;
          STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
          default:     out_stall = ~out_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int b;
    int e;
    int burst_left;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_LOAD;
    bone_index = 1'b0;
    entry_index = '0;
    entry_value = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    weight_zero = '0;
    weight_one = '0;
    hold_req = 1'b0;
    idle_cycles = 0;
    loads_sent = 0;
    unused_loads = 0;
    vertices_sent = 0;
    passes_sent = 0;
    start_matrix = '{'{ONE_Q, 0, 0, 3 * ONE_Q, 0, ONE_Q, 0, -2 * ONE_Q, 0, 0, ONE_Q, ONE_Q / 2},
                     '{WORD_MAX, WORD_MIN, -ONE_Q, ONE_Q, 0, 0, -ONE_Q, 5 * ONE_Q,
                       0, ONE_Q, 0, WORD_MIN}};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // every matrix word written before any vertex reads it
    for (b = 0; b < NUM_BONES; b++)
      for (e = 0; e < MAT_WORDS; e++)
        load_word(1'(b), ENTRY_W'(e), start_matrix[b][e]);
    load_word(1'b0, ENTRY_W'(MAT_WORDS), WORD_MAX);
    load_word(1'b1, ENTRY_W'(ENTRY_TOP), WORD_MIN);
    skin(ONE_Q, 2 * ONE_Q, -3 * ONE_Q, '0, '0);
    skin(ONE_Q, 2 * ONE_Q, -3 * ONE_Q, '0, W_ONE);
    skin(ONE_Q, 2 * ONE_Q, -3 * ONE_Q, W_ONE, W_ONE / 2);
    skin(-ONE_Q, ONE_Q / 3, 7 * ONE_Q, '0, weight_t'(WEIGHT_TOP));
    skin(WORD_MAX, WORD_MIN, '0, W_ONE, W_ONE);
    skin(WORD_MIN, -1, WORD_MAX, weight_t'(WEIGHT_TOP), weight_t'(WEIGHT_TOP));
    skin(WORD_MIN, WORD_MAX, -1, W_ONE, W_ONE - 1);
    skin('0, '0, '0, '0, weight_t'(1));
    skin(WORD_MAX, WORD_MAX, WORD_MIN, W_ONE - 1, W_ONE);

    burst_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) begin
        // output held off while the sender keeps offering vertices
        hold_req = 1'b1;
        repeat (HOLD_BURST) random_vertex();
        hold_req = 1'b0;
      end
      if (n == DRAIN_AT) begin
        idle(1);
        wait (pending == 0);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
      end
      burst_left--;
      if ($urandom_range(0, 3) == 0)
        random_load();
      else
        random_vertex();
    end

    idle(1);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d matrix loads (%0d to unused entries)",
             loads_sent, unused_loads);
    $display("and %0d vertices (%0d passed through)", vertices_sent, passes_sent);
    $display("with random output stalls, one %0d-cycle hold-off and one full drain pause",
             LONG_HOLD);
    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
